/* rtl/cp_tensor_sgd_update_unit_assert.svh */
// Assertion macros for the CP tensor SGD update unit
`ifndef CP_TENSOR_SGD_UPDATE_UNIT_ASSERT_SVH
`define CP_TENSOR_SGD_UPDATE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define CTS_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CTS_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define CTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/cts_pkg.sv */
// Shared types, constants and arithmetic helpers for the CP tensor SGD unit
`timescale 1ns / 1ps
`default_nettype none
package cts_pkg;
  localparam int ROWS_A = 1024;
  localparam int ROWS_B = 1024;
  localparam int ROWS_C = 1024;
  localparam int RANK = 16;
  localparam int COL_W = 4;
  localparam int ROW_W = 10;
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int DEPTH = ROWS_A * RANK;
  localparam int FRAC = 24;
  localparam logic [30:0] LR_RESET = 31'd167772;
  localparam logic [4:0] RANK_RESET = 5'd16;

  localparam logic [1:0] ACT_OBS = 2'd0;
  localparam logic [1:0] ACT_WR = 2'd1;
  localparam logic [1:0] ACT_RD = 2'd2;
  localparam logic [1:0] ACT_NONE = 2'd3;

  localparam logic [2:0] REG_LR = 3'd0;
  localparam logic [2:0] REG_RA = 3'd1;
  localparam logic [2:0] REG_RB = 3'd2;
  localparam logic [2:0] REG_RC = 3'd3;
  localparam logic [2:0] REG_RANK = 3'd4;

  // datapath operations issued by the controller
  typedef enum logic [2:0] {
    OP_IDLE  = 3'd0,
    OP_READ  = 3'd1, // issue memory read for column
    OP_PRED  = 3'd2, // accumulate triple product
    OP_LOSS  = 3'd3, // form loss
    OP_UPD   = 3'd4, // compute one update step
    OP_WRITE = 3'd5  // write updated column
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [1:0]       phase;  // sub-step within OP_PRED / OP_UPD
    logic [COL_W-1:0] col;
    logic             clr;    // clear accumulator and flag
  } dp_cmd_t;

  // saturate 64-bit signed to 32
  function automatic logic [32:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return {1'b1, 32'h7fffffff};
    if (x < -64'sd2147483648) return {1'b1, 32'h80000000};
    return {1'b0, x[31:0]};
  endfunction
endpackage
`default_nettype wire

/* rtl/cts_if.sv */
// Valid/ready channel interfaces for the CP tensor SGD unit
`timescale 1ns / 1ps
`default_nettype none
interface cts_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [1:0]  mode_sel;
  logic [9:0]  index_a;
  logic [9:0]  index_b;
  logic [9:0]  index_c;
  logic [3:0]  factor_col;
  logic signed [31:0] value;
  modport source (output valid, action, mode_sel, index_a, index_b, index_c, factor_col,
                  value, input ready);
  modport sink (input valid, action, mode_sel, index_a, index_b, index_c, factor_col,
                value, output ready);
endinterface

interface cts_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic signed [31:0] result_value;
  logic        saturated;
  modport source (output valid, result_kind, result_value, saturated, input ready);
  modport sink (input valid, result_kind, result_value, saturated, output ready);
endinterface

interface cts_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/cts_ram.sv */
// Single-port factor memory with registered read
`timescale 1ns / 1ps
`default_nettype none
module cts_ram #(
  parameter int AW = 14,
  parameter int DW = 32
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] addr,
  input  wire logic [DW-1:0] wdata,
  output logic      [DW-1:0] rdata
);
  logic [DW-1:0] mem [2**AW];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

/* rtl/cts_datapath.sv */
// Datapath: factor memories, shared multiplier, accumulator and update logic
`timescale 1ns / 1ps
`default_nettype none
module cts_datapath (
  input  wire logic              clk,
  input  wire cts_pkg::dp_cmd_t  cmd,
  input  wire logic              load,      // capture input item
  input  wire logic [1:0]        action,
  input  wire logic [1:0]        mode_sel,
  input  wire logic [9:0]        index_a,
  input  wire logic [9:0]        index_b,
  input  wire logic [9:0]        index_c,
  input  wire logic [3:0]        factor_col,
  input  wire logic [31:0]       value,
  input  wire logic [30:0]       step_rate,
  input  wire logic [30:0]       reg_a,
  input  wire logic [30:0]       reg_b,
  input  wire logic [30:0]       reg_c,
  output logic [31:0]            res_value,
  output logic                   res_sat
);
  logic [1:0]  act_r, mode_r;
  logic [9:0]  ia_r, ib_r, ic_r;
  logic [3:0]  col_r;
  logic signed [31:0] val_r;
  logic signed [31:0] a_r, b_r, c_r;      // old column values
  logic signed [31:0] ra, rb, rc;
  logic signed [31:0] t_r, g_r;            // temporaries
  logic signed [31:0] na_r, nb_r, nc_r;
  logic signed [31:0] loss_r;
  logic signed [37:0] acc_r;
  logic        sat_r;
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod;
  logic signed [63:0] shifted;
  logic [32:0] mq;
  logic [32:0] sd;
  logic signed [31:0] dsel, ssel, o1, o2;
  logic signed [31:0] regsel;
  logic [1:0]  which;                      // 0 a, 1 b, 2 c for update
  logic        we_a, we_b, we_c;
  logic [cts_pkg::ADDR_W-1:0] ad_a, ad_b, ad_c;
  logic [31:0] wd_a, wd_b, wd_c;
  logic [32:0] ps, lo, pc;
  logic [31:0] rd_sel;

  assign which = cmd.col[1:0];
  // update uses col[1:0] as target selector only during OP_UPD; column held in col_r
  always_comb begin
    ma = '0; mb = '0; o1 = b_r; o2 = c_r; ssel = a_r; regsel = {1'b0, reg_a};
    case (which)
      2'd1: begin o1 = a_r; o2 = c_r; ssel = b_r; regsel = {1'b0, reg_b}; end
      2'd2: begin o1 = a_r; o2 = b_r; ssel = c_r; regsel = {1'b0, reg_c}; end
      default: ;
    endcase
    case (cmd.op)
      cts_pkg::OP_PRED: begin
        if (cmd.phase == 2'd0) begin ma = ra; mb = rb; end
        else begin ma = t_r; mb = c_r; end
      end
      cts_pkg::OP_UPD: begin
        case (cmd.phase)
          2'd0: begin ma = loss_r; mb = o1; end
          2'd1: begin ma = t_r; mb = o2; end
          2'd2: begin ma = regsel; mb = ssel; end
          default: begin ma = {1'b0, step_rate}; mb = dsel; end
        endcase
      end
      default: ;
    endcase
  end
  assign prod = ma * mb;
  assign shifted = prod >>> cts_pkg::FRAC;   // arithmetic shift floors
  assign mq = cts_pkg::sat32(shifted);
  assign sd = cts_pkg::sat32(64'(t_r) - 64'(g_r));
  assign dsel = sd[31:0];
  assign ps = cts_pkg::sat32(64'(ssel) + 64'(signed'(mq[31:0])));
  // prediction is clamped before the loss is formed
  assign pc = cts_pkg::sat32(64'(acc_r));
  assign lo = cts_pkg::sat32(64'(val_r) - 64'(signed'(pc[31:0])));

  always_comb begin
    ad_a = {ia_r, col_r};
    ad_b = {ib_r, col_r};
    ad_c = {ic_r, col_r};
    if ((cmd.op == cts_pkg::OP_READ || cmd.op == cts_pkg::OP_WRITE) &&
        act_r == cts_pkg::ACT_OBS) begin
      ad_a = {ia_r, cmd.col}; ad_b = {ib_r, cmd.col}; ad_c = {ic_r, cmd.col};
    end
    we_a = 1'b0; we_b = 1'b0; we_c = 1'b0;
    wd_a = na_r; wd_b = nb_r; wd_c = nc_r;
    if (cmd.op == cts_pkg::OP_WRITE) begin
      if (act_r == cts_pkg::ACT_OBS) begin
        we_a = 1'b1; we_b = 1'b1; we_c = 1'b1;
      end else begin
        wd_a = val_r; wd_b = val_r; wd_c = val_r;
        we_a = (mode_r == 2'd0); we_b = (mode_r == 2'd1); we_c = (mode_r == 2'd2);
      end
    end
  end

  cts_ram #(.AW(cts_pkg::ADDR_W), .DW(32)) u_ram_a (
    .clk(clk), .we(we_a), .addr(ad_a), .wdata(wd_a), .rdata(ra));
  cts_ram #(.AW(cts_pkg::ADDR_W), .DW(32)) u_ram_b (
    .clk(clk), .we(we_b), .addr(ad_b), .wdata(wd_b), .rdata(rb));
  cts_ram #(.AW(cts_pkg::ADDR_W), .DW(32)) u_ram_c (
    .clk(clk), .we(we_c), .addr(ad_c), .wdata(wd_c), .rdata(rc));

  always_comb begin
    case (mode_r)
      2'd0: rd_sel = ra;
      2'd1: rd_sel = rb;
      2'd2: rd_sel = rc;
      default: rd_sel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      act_r <= action; mode_r <= mode_sel;
      ia_r <= index_a; ib_r <= index_b; ic_r <= index_c;
      col_r <= factor_col; val_r <= value;
    end
    if (cmd.clr) begin
      acc_r <= '0; sat_r <= 1'b0;
    end
    case (cmd.op)
      cts_pkg::OP_PRED: begin
        if (cmd.phase == 2'd0) begin
          a_r <= ra; b_r <= rb; c_r <= rc; t_r <= mq[31:0];
        end else begin
          acc_r <= acc_r + 38'(signed'(mq[31:0]));
        end
        sat_r <= sat_r | mq[32];
      end
      cts_pkg::OP_LOSS: begin
        loss_r <= lo[31:0];
        sat_r <= sat_r | pc[32] | lo[32];
      end
      cts_pkg::OP_READ: begin
        if (cmd.phase == 2'd1) col_r <= cmd.col;
      end
      cts_pkg::OP_UPD: begin
        case (cmd.phase)
          2'd0: begin t_r <= mq[31:0]; sat_r <= sat_r | mq[32]; end
          2'd1: begin t_r <= mq[31:0]; sat_r <= sat_r | mq[32]; end
          2'd2: begin g_r <= mq[31:0]; sat_r <= sat_r | mq[32]; end
          default: begin
            sat_r <= sat_r | mq[32] | sd[32] | ps[32];
            case (which)
              2'd0: na_r <= ps[31:0];
              2'd1: nb_r <= ps[31:0];
              default: nc_r <= ps[31:0];
            endcase
          end
        endcase
      end
      default: ;
    endcase
  end

  // swap: phase 2 stores reg product in g_r but difference is grad - reg
  always_comb begin
    res_sat = sat_r;
    case (act_r)
      cts_pkg::ACT_OBS: res_value = loss_r;
      cts_pkg::ACT_RD: res_value = ({1'b0, col_r} < 5'(cts_pkg::RANK)) ? rd_sel : '0;
      default: res_value = '0;
    endcase
    if (act_r != cts_pkg::ACT_OBS) res_sat = 1'b0;
  end
endmodule
`default_nettype wire

/* rtl/cts_ctrl.sv */
// Controller state machine sequencing the CP tensor SGD datapath
`timescale 1ns / 1ps
`default_nettype none
`include "cp_tensor_sgd_update_unit_assert.svh"
module cts_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_fire,
  input  wire logic [1:0]       action,
  input  wire logic [4:0]       rank_in_use,
  input  wire logic             out_ready,
  output logic                  in_ready,
  output logic                  out_valid,
  output logic [1:0]            out_kind,
  output cts_pkg::dp_cmd_t      cmd
);
  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_RD   = 8'b00000010,
    S_P0   = 8'b00000100,
    S_P1   = 8'b00001000,
    S_LOSS = 8'b00010000,
    S_UPD  = 8'b00100000,
    S_WR   = 8'b01000000,
    S_OUT  = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;
  logic [4:0] col_r, col_nxt;
  logic [1:0] step_r, step_nxt;  // update sub-step
  logic [1:0] tgt_r, tgt_nxt;    // which factor is updated
  logic [1:0] kind_r, kind_nxt;
  logic [4:0] nact;
  logic       upd_pass_r, upd_pass_nxt;

  assign nact = (rank_in_use > 5'(cts_pkg::RANK)) ? 5'(cts_pkg::RANK) : rank_in_use;
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_kind = kind_r;

  always_comb begin
    state_nxt = state_r; col_nxt = col_r; step_nxt = step_r; tgt_nxt = tgt_r;
    kind_nxt = kind_r; upd_pass_nxt = upd_pass_r;
    cmd = '{op: cts_pkg::OP_IDLE, phase: 2'd0, col: '0, clr: 1'b0};
    case (state_r)
      S_IDLE: if (in_fire) begin
        kind_nxt = action; col_nxt = '0; upd_pass_nxt = 1'b0;
        cmd.clr = 1'b1;
        case (action)
          cts_pkg::ACT_OBS: state_nxt = (nact == 5'd0) ? S_LOSS : S_RD;
          cts_pkg::ACT_WR: state_nxt = S_WR;
          cts_pkg::ACT_RD: state_nxt = S_RD;
          default: state_nxt = S_OUT;
        endcase
      end
      S_RD: begin
        cmd.op = cts_pkg::OP_READ;
        cmd.col = (kind_r == cts_pkg::ACT_OBS) ? col_r[3:0] : 4'd0;
        if (kind_r == cts_pkg::ACT_RD) state_nxt = S_P0; // read waits in S_P0 for registered data
        else state_nxt = S_P0;
      end
      S_P0: begin
        if (kind_r == cts_pkg::ACT_RD) state_nxt = S_OUT;
        else begin
          cmd.op = cts_pkg::OP_PRED; cmd.phase = 2'd0;
          state_nxt = upd_pass_r ? S_UPD : S_P1;
          tgt_nxt = 2'd0; step_nxt = 2'd0;
        end
      end
      S_P1: begin
        cmd.op = cts_pkg::OP_PRED; cmd.phase = 2'd1;
        if (col_r + 5'd1 >= nact) begin
          state_nxt = S_LOSS; col_nxt = '0;
        end else begin
          col_nxt = col_r + 5'd1; state_nxt = S_RD;
        end
      end
      S_LOSS: begin
        cmd.op = cts_pkg::OP_LOSS;
        upd_pass_nxt = 1'b1;
        state_nxt = (nact == 5'd0) ? S_OUT : S_RD;
      end
      S_UPD: begin
        cmd.op = cts_pkg::OP_UPD; cmd.phase = step_r; cmd.col = {2'b00, tgt_r};
        step_nxt = step_r + 2'd1;
        if (step_r == 2'd3) begin
          if (tgt_r == 2'd2) state_nxt = S_WR;
          else tgt_nxt = tgt_r + 2'd1;
        end
      end
      S_WR: begin
        cmd.op = cts_pkg::OP_WRITE; cmd.col = col_r[3:0];
        if (kind_r == cts_pkg::ACT_OBS && col_r + 5'd1 < nact) begin
          col_nxt = col_r + 5'd1; state_nxt = S_RD;
        end else state_nxt = S_OUT;
      end
      S_OUT: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; col_r <= '0; step_r <= '0; tgt_r <= '0; kind_r <= '0;
      upd_pass_r <= 1'b0;
    end else begin
      state_r <= state_nxt; col_r <= col_nxt; step_r <= step_nxt; tgt_r <= tgt_nxt;
      kind_r <= kind_nxt; upd_pass_r <= upd_pass_nxt;
    end
  end

  `CTS_ASSERT_IMPL(a_onehot, clk, rst_n, $onehot(state_r), "state not one-hot")
  `CTS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid,
                   "result dropped")
  `CTS_ASSERT_IMPL(a_no_accept_busy, clk, rst_n, !(in_fire && state_r != S_IDLE),
                   "transfer accepted while busy")
  `CTS_ASSERT_NEXT(a_col_range, clk, rst_n, state_r == S_WR, col_r < 5'(cts_pkg::RANK),
                   "column beyond rank")
endmodule
`default_nettype wire

/* rtl/cp_tensor_sgd_update_unit.sv */
// Top level: CP tensor SGD update unit
// Observe: a prediction pass over the n active columns, then an update pass, sequenced
// by the single shared multiplier through prediction and three updates per column.
// One item in flight at a time.
// Result is held in the output register until its transfer completes.
// Reset (rst_n low, synchronous) restores control and configuration registers; factor memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module cp_tensor_sgd_update_unit (
  input wire logic   clk,
  input wire logic   rst_n,
  cts_in_if.sink     in_ch,
  cts_out_if.source  out_ch,
  cts_cfg_if.sink    cfg_ch
);
  logic [30:0] lr_r, ra_r, rb_r, rc_r;
  logic [4:0]  rank_r;
  logic        in_fire;
  cts_pkg::dp_cmd_t cmd;
  logic [31:0] res_value;
  logic        res_sat;
  logic [1:0]  kind;

  assign cfg_ch.ready = 1'b1;
  assign in_fire = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r <= cts_pkg::LR_RESET; ra_r <= '0; rb_r <= '0; rc_r <= '0;
      rank_r <= cts_pkg::RANK_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        cts_pkg::REG_LR: lr_r <= cfg_ch.data[30:0];
        cts_pkg::REG_RA: ra_r <= cfg_ch.data[30:0];
        cts_pkg::REG_RB: rb_r <= cfg_ch.data[30:0];
        cts_pkg::REG_RC: rc_r <= cfg_ch.data[30:0];
        cts_pkg::REG_RANK: rank_r <= cfg_ch.data[4:0];
        default: ;
      endcase
    end
  end

  cts_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .action(in_ch.action),
    .rank_in_use(rank_r), .out_ready(out_ch.ready), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_kind(kind), .cmd(cmd));

  cts_datapath u_dp (
    .clk(clk), .cmd(cmd), .load(in_fire), .action(in_ch.action),
    .mode_sel(in_ch.mode_sel), .index_a(in_ch.index_a), .index_b(in_ch.index_b),
    .index_c(in_ch.index_c), .factor_col(in_ch.factor_col), .value(in_ch.value),
    .step_rate(lr_r), .reg_a(ra_r), .reg_b(rb_r), .reg_c(rc_r),
    .res_value(res_value), .res_sat(res_sat));

  assign out_ch.result_kind = kind;
  assign out_ch.result_value = res_value;
  assign out_ch.saturated = res_sat;
endmodule
`default_nettype wire
